// ===== src/ycp_pkg.sv =====
`default_nettype none

package ycp_pkg;

    localparam int FRAC_BITS = 12;

    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 14;
    localparam int DIFF_W  = PIX_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int ACC_W   = PROD_W + 2;

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_IW  = 3;

    localparam logic [REG_IW-1:0] REG_LUMA_GAIN     = 3'd0;
    localparam logic [REG_IW-1:0] REG_CR_TO_RED     = 3'd1;
    localparam logic [REG_IW-1:0] REG_CB_TO_GREEN   = 3'd2;
    localparam logic [REG_IW-1:0] REG_CR_TO_GREEN   = 3'd3;
    localparam logic [REG_IW-1:0] REG_CB_TO_BLUE    = 3'd4;
    localparam logic [REG_IW-1:0] REG_LUMA_OFFSET   = 3'd5;
    localparam logic [REG_IW-1:0] REG_CHROMA_OFFSET = 3'd6;

    localparam logic [GAIN_W-1:0] RST_LUMA_GAIN     = 14'd4769;
    localparam logic [GAIN_W-1:0] RST_CR_TO_RED     = 14'd6537;
    localparam logic [GAIN_W-1:0] RST_CB_TO_GREEN   = 14'd1605;
    localparam logic [GAIN_W-1:0] RST_CR_TO_GREEN   = 14'd3330;
    localparam logic [GAIN_W-1:0] RST_CB_TO_BLUE    = 14'd8391;
    localparam logic [PIX_W-1:0]  RST_LUMA_OFFSET   = 8'd16;
    localparam logic [PIX_W-1:0]  RST_CHROMA_OFFSET = 8'd128;

    typedef struct packed {
        logic [PIX_W-1:0] luma_left;
        logic [PIX_W-1:0] luma_right;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
    } ycp_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_left;
        logic [PIX_W-1:0] green_left;
        logic [PIX_W-1:0] blue_left;
        logic [PIX_W-1:0] red_right;
        logic [PIX_W-1:0] green_right;
        logic [PIX_W-1:0] blue_right;
    } ycp_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0] luma_gain;
        logic [GAIN_W-1:0] cr_to_red;
        logic [GAIN_W-1:0] cb_to_green;
        logic [GAIN_W-1:0] cr_to_green;
        logic [GAIN_W-1:0] cb_to_blue;
        logic [PIX_W-1:0]  luma_offset;
        logic [PIX_W-1:0]  chroma_offset;
    } ycp_cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } ycp_pipe_en_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] cr_red;
        logic signed [PROD_W-1:0] cb_green;
        logic signed [PROD_W-1:0] cr_green;
        logic signed [PROD_W-1:0] cb_blue;
    } ycp_chroma_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } ycp_rgb_t;

    // Drop the fraction and clamp to one byte; negative sums give black.
    function automatic logic [PIX_W-1:0] sat_channel(input logic signed [ACC_W-1:0] acc);
        logic [PIX_W-1:0] res;
        if (acc[ACC_W-1])
        begin
            res = '0;
        end
        else if (|acc[ACC_W-2:FRAC_BITS+PIX_W])
        begin
            res = '1;
        end
        else
        begin
            res = acc[FRAC_BITS+PIX_W-1:FRAC_BITS];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/ycp_regs.sv =====
`default_nettype none

module ycp_regs
    import ycp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output ycp_cfg_t               cfg
);

    ycp_cfg_t          cfg_reg;
    ycp_cfg_t          cfg_next;
    logic [REG_IW-1:0] reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_LUMA_GAIN:     cfg_next.luma_gain     = pwdata[GAIN_W-1:0];
                REG_CR_TO_RED:     cfg_next.cr_to_red     = pwdata[GAIN_W-1:0];
                REG_CB_TO_GREEN:   cfg_next.cb_to_green   = pwdata[GAIN_W-1:0];
                REG_CR_TO_GREEN:   cfg_next.cr_to_green   = pwdata[GAIN_W-1:0];
                REG_CB_TO_BLUE:    cfg_next.cb_to_blue    = pwdata[GAIN_W-1:0];
                REG_LUMA_OFFSET:   cfg_next.luma_offset   = pwdata[PIX_W-1:0];
                REG_CHROMA_OFFSET: cfg_next.chroma_offset = pwdata[PIX_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LUMA_GAIN:     prdata = APB_DW'(cfg_reg.luma_gain);
            REG_CR_TO_RED:     prdata = APB_DW'(cfg_reg.cr_to_red);
            REG_CB_TO_GREEN:   prdata = APB_DW'(cfg_reg.cb_to_green);
            REG_CR_TO_GREEN:   prdata = APB_DW'(cfg_reg.cr_to_green);
            REG_CB_TO_BLUE:    prdata = APB_DW'(cfg_reg.cb_to_blue);
            REG_LUMA_OFFSET:   prdata = APB_DW'(cfg_reg.luma_offset);
            REG_CHROMA_OFFSET: prdata = APB_DW'(cfg_reg.chroma_offset);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.luma_gain     <= RST_LUMA_GAIN;
            cfg_reg.cr_to_red     <= RST_CR_TO_RED;
            cfg_reg.cb_to_green   <= RST_CB_TO_GREEN;
            cfg_reg.cr_to_green   <= RST_CR_TO_GREEN;
            cfg_reg.cb_to_blue    <= RST_CB_TO_BLUE;
            cfg_reg.luma_offset   <= RST_LUMA_OFFSET;
            cfg_reg.chroma_offset <= RST_CHROMA_OFFSET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ycp_chroma.sv =====
`default_nettype none

module ycp_chroma
    import ycp_pkg::*;
(
    input  wire logic             clk,
    input  wire ycp_pipe_en_t     en,
    input  wire logic [PIX_W-1:0] chroma_blue,
    input  wire logic [PIX_W-1:0] chroma_red,
    input  wire ycp_cfg_t         cfg,
    output ycp_chroma_t           terms
);

    logic signed [DIFF_W-1:0] cb_reg;
    logic signed [DIFF_W-1:0] cr_reg;
    logic signed [DIFF_W-1:0] cb_next;
    logic signed [DIFF_W-1:0] cr_next;
    ycp_chroma_t              terms_reg;
    ycp_chroma_t              terms_next;

    assign cb_next = $signed({1'b0, chroma_blue}) - $signed({1'b0, cfg.chroma_offset});
    assign cr_next = $signed({1'b0, chroma_red}) - $signed({1'b0, cfg.chroma_offset});

    // The chroma products are shared by both pixels of the pair.
    always_comb
    begin
        terms_next.cr_red   = PROD_W'(cr_reg) * PROD_W'($signed({1'b0, cfg.cr_to_red}));
        terms_next.cb_green = PROD_W'(cb_reg) * PROD_W'($signed({1'b0, cfg.cb_to_green}));
        terms_next.cr_green = PROD_W'(cr_reg) * PROD_W'($signed({1'b0, cfg.cr_to_green}));
        terms_next.cb_blue  = PROD_W'(cb_reg) * PROD_W'($signed({1'b0, cfg.cb_to_blue}));
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            cb_reg <= cb_next;
            cr_reg <= cr_next;
        end
        if (en.s2)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

`default_nettype wire

// ===== src/ycp_lane.sv =====
`default_nettype none

module ycp_lane
    import ycp_pkg::*;
(
    input  wire logic             clk,
    input  wire ycp_pipe_en_t     en,
    input  wire logic [PIX_W-1:0] luma,
    input  wire ycp_cfg_t         cfg,
    input  wire ycp_chroma_t      terms,
    output ycp_rgb_t              rgb
);

    logic signed [DIFF_W-1:0] y_reg;
    logic signed [DIFF_W-1:0] y_next;
    logic signed [PROD_W-1:0] base_reg;
    logic signed [PROD_W-1:0] base_next;
    logic signed [ACC_W-1:0]  red_sum;
    logic signed [ACC_W-1:0]  green_sum;
    logic signed [ACC_W-1:0]  blue_sum;
    ycp_rgb_t                 rgb_reg;
    ycp_rgb_t                 rgb_next;

    assign y_next    = $signed({1'b0, luma}) - $signed({1'b0, cfg.luma_offset});
    assign base_next = PROD_W'(y_reg) * PROD_W'($signed({1'b0, cfg.luma_gain}));

    always_comb
    begin
        red_sum   = ACC_W'(base_reg) + ACC_W'(terms.cr_red);
        green_sum = ACC_W'(base_reg) - ACC_W'(terms.cb_green) - ACC_W'(terms.cr_green);
        blue_sum  = ACC_W'(base_reg) + ACC_W'(terms.cb_blue);
        rgb_next.red   = sat_channel(red_sum);
        rgb_next.green = sat_channel(green_sum);
        rgb_next.blue  = sat_channel(blue_sum);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            y_reg <= y_next;
        end
        if (en.s2)
        begin
            base_reg <= base_next;
        end
        if (en.s3)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

`default_nettype wire

// ===== src/ycbcr_pair_to_rgb_top.sv =====
// Channel   | Direction | Handshake                 | Payload
// pix       | in        | pix_valid / pix_stall     | ycp_in_t: two luma samples, Cb, Cr
// rgb       | out       | rgb_valid / rgb_stall     | ycp_out_t: RGB of the even and odd pixel
// apb       | in        | psel / penable / pready   | seven coefficient and offset registers
//
// One pixel pair is taken every clock while no stall holds the pipeline.
// The three stages are offset subtraction, the multipliers, and the sum with saturation.
// Each stage holds only while a later stage is full and the output is stalled, so a
// bubble is squeezed out before the input sees a stall.
// Reset clears the stage valid flags and loads the reset coefficients of ycp_pkg.
`default_nettype none

module ycbcr_pair_to_rgb_top
    import ycp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pix_valid,
    output logic                   pix_stall,
    input  wire ycp_in_t           pix_data,
    output logic                   rgb_valid,
    input  wire logic              rgb_stall,
    output ycp_out_t               rgb_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    ycp_cfg_t     cfg;
    ycp_pipe_en_t en;
    ycp_chroma_t  terms;
    ycp_rgb_t     rgb_l;
    ycp_rgb_t     rgb_r;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;

    assign en.s3 = !v3_reg || !rgb_stall;
    assign en.s2 = !v2_reg || en.s3;
    assign en.s1 = !v1_reg || en.s2;

    assign pix_stall = !en.s1;

    assign v1_next = en.s1 ? pix_valid : v1_reg;
    assign v2_next = en.s2 ? v1_reg : v2_reg;
    assign v3_next = en.s3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    ycp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ycp_chroma u_chroma (
        .clk         (clk),
        .en          (en),
        .chroma_blue (pix_data.chroma_blue),
        .chroma_red  (pix_data.chroma_red),
        .cfg         (cfg),
        .terms       (terms)
    );

    ycp_lane u_lane_left (
        .clk   (clk),
        .en    (en),
        .luma  (pix_data.luma_left),
        .cfg   (cfg),
        .terms (terms),
        .rgb   (rgb_l)
    );

    ycp_lane u_lane_right (
        .clk   (clk),
        .en    (en),
        .luma  (pix_data.luma_right),
        .cfg   (cfg),
        .terms (terms),
        .rgb   (rgb_r)
    );

    assign rgb_valid            = v3_reg;
    assign rgb_data.red_left    = rgb_l.red;
    assign rgb_data.green_left  = rgb_l.green;
    assign rgb_data.blue_left   = rgb_l.blue;
    assign rgb_data.red_right   = rgb_r.red;
    assign rgb_data.green_right = rgb_r.green;
    assign rgb_data.blue_right  = rgb_r.blue;

endmodule

`default_nettype wire

// ===== src/ycp_checker.sv =====
`default_nettype none

module ycp_checker
    import ycp_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     pix_valid,
    input wire logic     pix_stall,
    input wire logic     rgb_valid,
    input wire logic     rgb_stall,
    input wire ycp_out_t rgb_data
);

    // A stalled result beat stays offered.
    a_rgb_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid)
        else $error("rgb_valid dropped while stalled");

    // A stalled result beat keeps its payload.
    a_rgb_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> $stable(rgb_data))
        else $error("rgb_data changed while stalled");

    // The input is only ever held off by back-pressure from the output.
    a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rgb_stall |-> !pix_stall)
        else $error("pix_stall raised with the output free");

    // An accepted beat reaches the output when the output drains.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall) ##2 !rgb_stall |=> rgb_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind ycbcr_pair_to_rgb_top ycp_checker u_ycp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb_data  (rgb_data)
);

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
    import ycp_pkg::*;

    localparam int PIPE_DEPTH  = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 15;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 115;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [REG_IW-1:0] REG_UNUSED = 3'd7;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              pix_valid = 1'b0;
    logic              pix_stall;
    ycp_in_t           pix_data  = '0;
    logic              rgb_valid;
    logic              rgb_stall = 1'b0;
    ycp_out_t          rgb_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ycp_cfg_t coeffs;
    ycp_out_t rgb_pending [$];
    int       errors = 0;

    string channel_names [6] = '{"red_left", "green_left", "blue_left",
                                 "red_right", "green_right", "blue_right"};

    // Directed pairs under the reset coefficients. Black and full-scale pairs carry
    // their answer in the table; the rest are left to the converter model below.
    ycp_in_t dir_pix [DIR_ROWS] = '{
        {8'd16,  8'd16,  8'd128, 8'd128},
        {8'd0,   8'd255, 8'd128, 8'd128},
        {8'd255, 8'd0,   8'd128, 8'd128},
        {8'd16,  8'd255, 8'd128, 8'd128},
        {8'd255, 8'd255, 8'd255, 8'd255},
        {8'd0,   8'd0,   8'd0,   8'd0},
        {8'd255, 8'd0,   8'd0,   8'd255},
        {8'd0,   8'd255, 8'd255, 8'd0},
        {8'd235, 8'd235, 8'd16,  8'd16},
        {8'd235, 8'd16,  8'd240, 8'd240},
        {8'd128, 8'd128, 8'd0,   8'd255},
        {8'd128, 8'd128, 8'd255, 8'd0},
        {8'd81,  8'd145, 8'd90,  8'd240},
        {8'd41,  8'd210, 8'd240, 8'd110},
        {8'd170, 8'd106, 8'd16,  8'd166}
    };
    bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    ycp_out_t dir_rgb [DIR_ROWS] = '{
        48'h000000_000000,
        48'h000000_FFFFFF,
        48'hFFFFFF_000000,
        48'h000000_FFFFFF,
        '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0
    };

    ycbcr_pair_to_rgb_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_data  (rgb_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        errors++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    function automatic logic [PIX_W-1:0] clamp_channel(input int acc);
        int v;
        if (acc < 0)
        begin
            return '0;
        end
        v = acc >>> FRAC_BITS;
        if (v > 255)
        begin
            return '1;
        end
        return v[PIX_W-1:0];
    endfunction

    function automatic ycp_rgb_t convert_pixel(input logic [PIX_W-1:0] luma,
                                               input int cb, input int cr);
        int       base;
        ycp_rgb_t px;
        base     = (int'(luma) - int'(coeffs.luma_offset)) * int'(coeffs.luma_gain);
        px.red   = clamp_channel(base + cr * int'(coeffs.cr_to_red));
        px.green = clamp_channel(base - cb * int'(coeffs.cb_to_green)
                                      - cr * int'(coeffs.cr_to_green));
        px.blue  = clamp_channel(base + cb * int'(coeffs.cb_to_blue));
        return px;
    endfunction

    function automatic ycp_out_t convert_pair(input ycp_in_t pix);
        int cb;
        int cr;
        cb = int'(pix.chroma_blue) - int'(coeffs.chroma_offset);
        cr = int'(pix.chroma_red) - int'(coeffs.chroma_offset);
        return {convert_pixel(pix.luma_left, cb, cr), convert_pixel(pix.luma_right, cb, cr)};
    endfunction

    task automatic update_coeff(input logic [REG_IW-1:0] idx, input logic [31:0] value);
        case (idx)
            REG_LUMA_GAIN:     coeffs.luma_gain     = value[GAIN_W-1:0];
            REG_CR_TO_RED:     coeffs.cr_to_red     = value[GAIN_W-1:0];
            REG_CB_TO_GREEN:   coeffs.cb_to_green   = value[GAIN_W-1:0];
            REG_CR_TO_GREEN:   coeffs.cr_to_green   = value[GAIN_W-1:0];
            REG_CB_TO_BLUE:    coeffs.cb_to_blue    = value[GAIN_W-1:0];
            REG_LUMA_OFFSET:   coeffs.luma_offset   = value[PIX_W-1:0];
            REG_CHROMA_OFFSET: coeffs.chroma_offset = value[PIX_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] coeff_value(input logic [REG_IW-1:0] idx);
        case (idx)
            REG_LUMA_GAIN:     return 32'(coeffs.luma_gain);
            REG_CR_TO_RED:     return 32'(coeffs.cr_to_red);
            REG_CB_TO_GREEN:   return 32'(coeffs.cb_to_green);
            REG_CR_TO_GREEN:   return 32'(coeffs.cr_to_green);
            REG_CB_TO_BLUE:    return 32'(coeffs.cb_to_blue);
            REG_LUMA_OFFSET:   return 32'(coeffs.luma_offset);
            REG_CHROMA_OFFSET: return 32'(coeffs.chroma_offset);
            default:           return '0;
        endcase
    endfunction

    task automatic reg_write(input logic [REG_IW-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        update_coeff(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check(input logic [REG_IW-1:0] idx);
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        got = prdata;
        if (got !== coeff_value(idx))
        begin
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      idx, got, coeff_value(idx)));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly no pause, sometimes a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] pick_byte(input logic [PIX_W-1:0] level);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return level + PIX_W'($urandom_range(0, 6)) - PIX_W'(3);
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // A beat is held until the block takes it; the next one follows at once or after a gap.
    task automatic send_pair(input ycp_in_t pix, input bit typed, input ycp_out_t rgb);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            pix_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix_valid <= 1'b1;
        pix_data  <= pix;
        do
        begin
            @(posedge clk);
        end
        while (!(pix_valid && !pix_stall));
        rgb_pending.push_back(typed ? rgb : convert_pair(pix));
    endtask

    task automatic drain();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (rgb_pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (rgb_pending.size() == 0)
            begin
                report_mismatch($sformatf("result beat %h with nothing expected", rgb_data));
            end
            else
            begin
                ycp_out_t exp_rgb;
                exp_rgb = rgb_pending.pop_front();
                for (int i = 0; i < 6; i++)
                begin
                    if (rgb_data[$bits(ycp_out_t)-1-8*i -: 8]
                        !== exp_rgb[$bits(ycp_out_t)-1-8*i -: 8])
                    begin
                        report_mismatch($sformatf("%s is %h, expected %h",
                            channel_names[i], rgb_data[$bits(ycp_out_t)-1-8*i -: 8],
                            exp_rgb[$bits(ycp_out_t)-1-8*i -: 8]));
                    end
                end
            end
        end
    end

    // Output back-pressure: runs of free flow broken by short and occasional long stalls.
    initial
    begin
        int n;
        forever
        begin
            n = $urandom_range(1, 24);
            rgb_stall <= 1'b0;
            repeat (n) @(negedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                rgb_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [31:0] vals [7];
        ycp_in_t     pix;

        coeffs.luma_gain     = RST_LUMA_GAIN;
        coeffs.cr_to_red     = RST_CR_TO_RED;
        coeffs.cb_to_green   = RST_CB_TO_GREEN;
        coeffs.cr_to_green   = RST_CR_TO_GREEN;
        coeffs.cb_to_blue    = RST_CB_TO_BLUE;
        coeffs.luma_offset   = RST_LUMA_OFFSET;
        coeffs.chroma_offset = RST_CHROMA_OFFSET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int idx = 0; idx < 7; idx++)
        begin
            reg_check(REG_IW'(idx));
        end

        for (int row = 0; row < DIR_ROWS; row++)
        begin
            send_pair(dir_pix[row], dir_typed[row], dir_rgb[row]);
        end
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                // Full-scale coefficients; the upper bits of each word must be dropped.
                1:
                begin
                    for (int idx = 0; idx < 7; idx++)
                    begin
                        vals[idx] = 32'hFFFF_FFFF;
                    end
                end
                // All zero in the kept bits, with rubbish above them.
                2:
                begin
                    for (int idx = 0; idx < 5; idx++)
                    begin
                        vals[idx] = 32'hFFFF_C000;
                    end
                    vals[REG_LUMA_OFFSET]   = 32'hFFFF_FF00;
                    vals[REG_CHROMA_OFFSET] = 32'hFFFF_FF00;
                end
                3:
                begin
                    for (int idx = 0; idx < 7; idx++)
                    begin
                        vals[idx] = $urandom();
                    end
                end
                4:
                begin
                    for (int idx = 0; idx < 5; idx++)
                    begin
                        vals[idx] = $urandom_range(1000, 9000);
                    end
                    vals[REG_LUMA_OFFSET]   = $urandom_range(0, 40);
                    vals[REG_CHROMA_OFFSET] = $urandom_range(100, 156);
                end
                5:
                begin
                    vals[REG_LUMA_GAIN]     = 32'(RST_LUMA_GAIN);
                    vals[REG_CR_TO_RED]     = 32'(RST_CR_TO_RED);
                    vals[REG_CB_TO_GREEN]   = 32'(RST_CB_TO_GREEN);
                    vals[REG_CR_TO_GREEN]   = 32'(RST_CR_TO_GREEN);
                    vals[REG_CB_TO_BLUE]    = 32'(RST_CB_TO_BLUE);
                    vals[REG_LUMA_OFFSET]   = 32'(RST_LUMA_OFFSET);
                    vals[REG_CHROMA_OFFSET] = 32'(RST_CHROMA_OFFSET);
                end
                default: ;
            endcase
            if (phase != 0)
            begin
                for (int idx = 0; idx < 7; idx++)
                begin
                    reg_write(REG_IW'(idx), vals[idx]);
                end
                reg_write(REG_UNUSED, $urandom());
                for (int idx = 0; idx < 7; idx++)
                begin
                    reg_check(REG_IW'(idx));
                end
            end

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pix.luma_left   = pick_byte(coeffs.luma_offset);
                pix.luma_right  = pick_byte(coeffs.luma_offset);
                pix.chroma_blue = pick_byte(coeffs.chroma_offset);
                pix.chroma_red  = pick_byte(coeffs.chroma_offset);
                send_pair(pix, 1'b0, '0);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
